// File: hw/rtl/tlpd_pkg.sv
`timescale 1ns / 1ps

package tlpd_pkg;

   // Header layout: type word of up to four bytes, then a 32-bit length
   localparam int unsigned LEN_BYTES = 4;
   localparam int unsigned MAX_TYPE_BYTES = 4;
   localparam int unsigned HCNT_W = 4;
   localparam logic [31:0] MAX_TYPE_RESET = 32'd15;

   // One received stream byte
   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] client_id;
   } req_beat_type;

   // One deframed result
   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [31:0] packet_type;
      logic [31:0] payload_length;
      logic [15:0] source_client;
      logic        first_flag;
      logic        last_flag;
      logic        empty_flag;
      logic        bad_type;
   } rsp_beat_type;

   // Core to output stage handoff
   typedef struct packed {
      logic         valid;
      rsp_beat_type beat;
   } rsp_push_type;

endpackage

// File: hw/rtl/tlpd_if.sv
`timescale 1ns / 1ps

// Input byte channel
interface tlpd_req_if;
   logic                  valid;
   logic                  ready;
   tlpd_pkg::req_beat_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// Result channel
interface tlpd_rsp_if;
   logic                  valid;
   logic                  ready;
   tlpd_pkg::rsp_beat_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// Register write channel
interface tlpd_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/typed_length_prefix_deframer.sv
`timescale 1ns / 1ps

// Channel   Modport  Beat                              Accepted when
// req_bus   sink     data_byte, client_id              valid && ready
// rsp_bus   source   payload byte, header, flags       valid && ready
// csr_bus   sink     max_type write data (32 bits)     valid && ready (ready tied high)
//
// One input beat per cycle while req_bus is ready; results leave from a register.
// Header counter counts header beats; the payload byte counter counts payload beats.
// Reset (synchronous) returns to header phase with max_type at 15.
// A two-entry output stage keeps req_bus ready while one result waits;
// req_bus stalls only when both entries are full.
// After a bad type, input beats are still taken and dropped until reset.

module typed_length_prefix_deframer #(
   parameter int unsigned TYPE_BYTES = 4
) (
   input logic        clock,
   input logic        reset,
   tlpd_req_if.sink   req_bus,
   tlpd_rsp_if.source rsp_bus,
   tlpd_csr_if.sink   csr_bus
);

   tlpd_pkg::rsp_push_type push;
   logic                   push_ready;

   // Header parsing and result formation
   tlpd_core #(
      .TYPE_BYTES (TYPE_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .push_ready (push_ready),
      .push       (push)
   );

   // Result register with skid
   tlpd_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: hw/rtl/tlpd_core.sv
`timescale 1ns / 1ps

module tlpd_core #(
   parameter int unsigned TYPE_BYTES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   tlpd_req_if.sink               req_bus,
   tlpd_csr_if.sink               csr_bus,
   input  logic                   push_ready,
   output tlpd_pkg::rsp_push_type push
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_HALT    = 2'd2
   } phase_type;

   localparam logic [tlpd_pkg::HCNT_W-1:0] HDR_LAST =
      tlpd_pkg::HCNT_W'(TYPE_BYTES + tlpd_pkg::LEN_BYTES - 1);

   phase_type                     phase_ff, phase_in;
   logic [tlpd_pkg::HCNT_W-1:0]   hcnt_ff, hcnt_in;
   logic [31:0]                   type_ff, type_in;
   logic [31:0]                   length_ff, length_in;
   logic [31:0]                   left_ff, left_in;
   logic [31:0]                   max_type_ff, max_type_in;
   logic [31:0]                   type_merge;
   logic [31:0]                   length_merge;
   logic                          fire;
   logic                          last_byte;

   assign req_bus.ready = push_ready;
   assign csr_bus.ready = 1'b1;
   assign fire = req_bus.valid && req_bus.ready;

   // Header byte lanes: a new header starts from zero words
   always_comb begin
      type_merge   = (hcnt_ff == '0) ? '0 : type_ff;
      length_merge = (hcnt_ff == '0) ? '0 : length_ff;
      for (int i = 0; i < tlpd_pkg::MAX_TYPE_BYTES; i++) begin
         if ((i < TYPE_BYTES) && (hcnt_ff == tlpd_pkg::HCNT_W'(i))) begin
            type_merge[8*i +: 8] = req_bus.payload.data_byte;
         end
      end
      for (int j = 0; j < tlpd_pkg::LEN_BYTES; j++) begin
         if (hcnt_ff == tlpd_pkg::HCNT_W'(TYPE_BYTES + j)) begin
            length_merge[8*j +: 8] = req_bus.payload.data_byte;
         end
      end
   end

   // Phase sequencing and result formation
   always_comb begin
      phase_in    = phase_ff;
      hcnt_in     = hcnt_ff;
      type_in     = type_ff;
      length_in   = length_ff;
      left_in     = left_ff;
      max_type_in = max_type_ff;
      last_byte   = (left_ff <= 32'd1);

      push.valid                     = 1'b0;
      push.beat.payload_byte         = '0;
      push.beat.packet_type          = type_ff;
      push.beat.payload_length       = length_ff;
      push.beat.source_client        = req_bus.payload.client_id;
      push.beat.first_flag           = 1'b0;
      push.beat.last_flag            = 1'b0;
      push.beat.empty_flag           = 1'b0;
      push.beat.bad_type             = 1'b0;

      if (csr_bus.valid && csr_bus.ready) begin
         max_type_in = csr_bus.data;
      end

      case (phase_ff)
         PH_HEADER: begin
            push.beat.packet_type    = type_merge;
            push.beat.payload_length = length_merge;
            if (fire) begin
               type_in   = type_merge;
               length_in = length_merge;
               if (hcnt_ff == HDR_LAST) begin
                  hcnt_in = '0;
                  if (type_merge > max_type_ff) begin
                     // bad type: report once, then take and drop all further beats until reset
                     phase_in           = PH_HALT;
                     push.valid         = 1'b1;
                     push.beat.bad_type = 1'b1;
                  end else if (length_merge == '0) begin
                     push.valid           = 1'b1;
                     push.beat.first_flag = 1'b1;
                     push.beat.last_flag  = 1'b1;
                     push.beat.empty_flag = 1'b1;
                  end else begin
                     left_in  = length_merge;
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  hcnt_in = hcnt_ff + 1'b1;
               end
            end
         end
         PH_PAYLOAD: begin
            if (fire) begin
               push.valid             = 1'b1;
               push.beat.payload_byte = req_bus.payload.data_byte;
               push.beat.first_flag   = (left_ff == length_ff);
               push.beat.last_flag    = last_byte;
               if (last_byte) begin
                  left_in  = '0;
                  hcnt_in  = '0;
                  phase_in = PH_HEADER;
               end else begin
                  left_in = left_ff - 32'd1;
               end
            end
         end
         default: begin
            // halted: beats are taken and dropped
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         hcnt_ff     <= '0;
         type_ff     <= '0;
         length_ff   <= '0;
         left_ff     <= '0;
         max_type_ff <= tlpd_pkg::MAX_TYPE_RESET;
      end else begin
         phase_ff    <= phase_in;
         hcnt_ff     <= hcnt_in;
         type_ff     <= type_in;
         length_ff   <= length_in;
         left_ff     <= left_in;
         max_type_ff <= max_type_in;
      end
   end

endmodule

// File: hw/rtl/tlpd_out_skid.sv
`timescale 1ns / 1ps

module tlpd_out_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  tlpd_pkg::rsp_push_type push,
   output logic                   push_ready,
   tlpd_rsp_if.source             rsp_bus
);

   logic                   main_valid_ff, main_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   tlpd_pkg::rsp_beat_type main_ff, main_in;
   tlpd_pkg::rsp_beat_type skid_ff, skid_in;
   logic                   push_fire;

   assign push_ready    = !skid_valid_ff;
   assign push_fire     = push.valid && push_ready;
   assign rsp_bus.valid = main_valid_ff;
   assign rsp_bus.payload = main_ff;

   // Main register feeds the port; skid catches a beat while main stalls
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || rsp_bus.ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push.beat;
            main_valid_in = push_fire;
         end
      end else if (push_fire) begin
         skid_in       = push.beat;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule
